[hw/rtl/half_single_float_converter_unit_assert.svh]
// Assertion macros used by the converter's top-level RTL file.
`ifndef HALF_SINGLE_FLOAT_CONVERTER_UNIT_ASSERT_SVH
`define HALF_SINGLE_FLOAT_CONVERTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Checks an implication property on every rising clock edge outside reset.
`define HSFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition never holds on a clock edge outside reset.
`define HSFC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HSFC_ASSERT(lbl, clk, rst_n, prop, msg)
`define HSFC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[hw/rtl/hsfc_pkg.sv]
// Package with the types and constants of the half/single float converter.
package hsfc_pkg;

    // Direction codes carried by the opcode field.
    localparam logic OP_H2S = 1'b0;
    localparam logic OP_S2H = 1'b1;

    // Field widths of the two formats.
    localparam int HALF_EXP_W = 5;
    localparam int HALF_FRAC_W = 10;
    localparam int SGL_EXP_W = 8;
    localparam int SGL_FRAC_W = 23;
    localparam int LZC_W = 4;

    // Exponent constants.
    localparam logic [HALF_EXP_W-1:0] HALF_EXP_MAX = 5'h1F;
    localparam logic [SGL_EXP_W-1:0] SGL_EXP_MAX = 8'hFF;
    localparam logic [SGL_EXP_W-1:0] BIAS_DIFF = 8'd112;

    // Class of a value after decode.
    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_INF,
        CLS_NAN,
        CLS_FINITE
    } t_cls;

endpackage

[hw/rtl/hsfc_if.sv]
// Stream interfaces for the converter's input and result channels.
interface hsfc_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] operand_bits;

    modport source (output valid, output opcode, output operand_bits, input ready);
    modport sink (input valid, input opcode, input operand_bits, output ready);
endinterface

interface hsfc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_bits;

    modport source (output valid, output result_bits, input ready);
    modport sink (input valid, input result_bits, output ready);
endinterface

[hw/rtl/hsfc_lzc.sv]
// Leading-zero counter over a half-precision fraction field.
module hsfc_lzc (
    input  logic [hsfc_pkg::HALF_FRAC_W-1:0] i_frac,
    output logic [hsfc_pkg::LZC_W-1:0]       o_count
);

    // Priority encode: the highest set bit wins, scanned from the bottom up.
    always_comb begin
        o_count = '0;
        for (int i = 0; i < hsfc_pkg::HALF_FRAC_W; i++) begin
            if (i_frac[i]) begin
                o_count = hsfc_pkg::LZC_W'(hsfc_pkg::HALF_FRAC_W - 1 - i);
            end
        end
    end

endmodule

[hw/rtl/half_single_float_converter_unit.sv]
// Top level of the half/single float converter: a three-stage pipeline.
//
//  Channel   Dir  Beat fields                  Role
//  i_in      in   opcode, operand_bits[31:0]   source pattern and direction
//  o_out     out  result_bits[31:0]            converted pattern
//
// One beat is accepted per cycle unless a stalled output has filled all stages; each
// result leaves through the stage 1, 2 and 3 registers, in input order.
// Stage 1 decodes and counts leading zeros, stage 2 aligns the fraction, and
// stage 3 assembles the result into the output register.
// A stalled output holds its beat; each stage refills as soon as it empties, so
// the input stays ready while any stage is free.
// Reset clears the stage valid bits only.
`include "half_single_float_converter_unit_assert.svh"

module half_single_float_converter_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hsfc_in_if.sink           i_in,
    hsfc_out_if.source        o_out
);

    // Stage control.
    logic s1_rdy;
    logic s2_rdy;
    logic s3_rdy;

    // Stage 1 registers.
    logic                r1_vld;
    logic                r1_op;
    logic                r1_sign;
    hsfc_pkg::t_cls      r1_cls;
    logic                r1_sub;
    logic [7:0]          r1_exp;
    logic [23:0]         r1_frac;
    logic [4:0]          r1_sh;

    // Stage 1 next values.
    hsfc_pkg::t_cls      n1_cls;
    logic                n1_sub;
    logic [7:0]          n1_exp;
    logic [23:0]         n1_frac;
    logic [4:0]          n1_sh;

    // Stage 2 registers.
    logic                r2_vld;
    logic                r2_op;
    logic                r2_sign;
    hsfc_pkg::t_cls      r2_cls;
    logic [7:0]          r2_exp;
    logic [22:0]         r2_frac;
    logic [22:0]         n2_frac;

    // Stage 3 registers.
    logic                r3_vld;
    logic                r3_op;
    logic [31:0]         r3_res;
    logic [31:0]         n3_res;

    // Decode helpers.
    logic [4:0]          h_exp;
    logic [9:0]          h_frac;
    logic [7:0]          s_exp;
    logic [22:0]         s_frac;
    logic signed [8:0]   s_ebias;
    logic [8:0]          s_shift;
    logic [3:0]          lz;
    logic [9:0]          h_sub_frac;

    // Ready chain: a stage takes a beat when it is empty or moves on.
    assign s3_rdy = !r3_vld || o_out.ready;
    assign s2_rdy = !r2_vld || s3_rdy;
    assign s1_rdy = !r1_vld || s2_rdy;
    assign i_in.ready = s1_rdy;

    assign h_exp  = i_in.operand_bits[14:10];
    assign h_frac = i_in.operand_bits[9:0];
    assign s_exp  = i_in.operand_bits[30:23];
    assign s_frac = i_in.operand_bits[22:0];
    assign s_ebias = $signed({1'b0, s_exp}) - $signed({1'b0, hsfc_pkg::BIAS_DIFF});
    assign s_shift = 9'd14 - s_ebias;

    hsfc_lzc u_lzc (
        .i_frac  (h_frac),
        .o_count (lz)
    );

    // Stage 1: classify the operand and work out exponent and shift amount.
    always_comb begin
        n1_cls  = hsfc_pkg::CLS_ZERO;
        n1_sub  = 1'b0;
        n1_exp  = '0;
        n1_frac = '0;
        n1_sh   = '0;
        if (i_in.opcode == hsfc_pkg::OP_H2S) begin
            n1_frac = {14'b0, h_frac};
            if (h_exp == '0) begin
                if (h_frac != '0) begin
                    n1_cls = hsfc_pkg::CLS_FINITE;
                    n1_sub = 1'b1;
                    n1_exp = hsfc_pkg::BIAS_DIFF - {4'b0, lz};
                    n1_sh  = {1'b0, lz} + 5'd1;
                end
            end else if (h_exp == hsfc_pkg::HALF_EXP_MAX) begin
                n1_cls = (h_frac == '0) ? hsfc_pkg::CLS_INF : hsfc_pkg::CLS_NAN;
            end else begin
                n1_cls = hsfc_pkg::CLS_FINITE;
                n1_exp = {3'b0, h_exp} + hsfc_pkg::BIAS_DIFF;
            end
        end else begin
            n1_frac = {1'b0, s_frac};
            if (s_exp == '0) begin
                n1_cls = hsfc_pkg::CLS_ZERO;
            end else if (s_exp == hsfc_pkg::SGL_EXP_MAX) begin
                n1_cls = (s_frac == '0) ? hsfc_pkg::CLS_INF : hsfc_pkg::CLS_NAN;
            end else if (s_ebias >= 9'sd31) begin
                n1_cls = hsfc_pkg::CLS_INF;
            end else if (s_ebias >= 9'sd1) begin
                n1_cls = hsfc_pkg::CLS_FINITE;
                n1_exp = {3'b0, s_ebias[4:0]};
            end else if (s_ebias >= -9'sd10) begin
                n1_cls  = hsfc_pkg::CLS_FINITE;
                n1_sub  = 1'b1;
                n1_frac = {1'b1, s_frac};
                n1_sh   = s_shift[4:0];
            end else begin
                n1_cls = hsfc_pkg::CLS_ZERO;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (s1_rdy) begin
            r1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r1_op   <= i_in.opcode;
            r1_sign <= (i_in.opcode == hsfc_pkg::OP_H2S) ? i_in.operand_bits[15]
                                                          : i_in.operand_bits[31];
            r1_cls  <= n1_cls;
            r1_sub  <= n1_sub;
            r1_exp  <= n1_exp;
            r1_frac <= n1_frac;
            r1_sh   <= n1_sh;
        end
    end

    // Stage 2: align the fraction into its place in the target format.
    assign h_sub_frac = 10'(r1_frac[9:0] << r1_sh);

    always_comb begin
        if (r1_op == hsfc_pkg::OP_H2S) begin
            n2_frac = {(r1_sub ? h_sub_frac : r1_frac[9:0]), 13'b0};
        end else if (r1_sub) begin
            n2_frac = {13'b0, 10'(r1_frac >> r1_sh)};
        end else begin
            n2_frac = {13'b0, r1_frac[22:13]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (s2_rdy) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_rdy) begin
            r2_op   <= r1_op;
            r2_sign <= r1_sign;
            r2_cls  <= r1_cls;
            r2_exp  <= r1_exp;
            r2_frac <= n2_frac;
        end
    end

    // Stage 3: assemble sign, exponent and fraction of the result.
    always_comb begin
        if (r2_op == hsfc_pkg::OP_H2S) begin
            case (r2_cls)
                hsfc_pkg::CLS_ZERO:   n3_res = {r2_sign, 31'b0};
                hsfc_pkg::CLS_INF:    n3_res = {r2_sign, hsfc_pkg::SGL_EXP_MAX, 23'b0};
                hsfc_pkg::CLS_NAN:    n3_res = {r2_sign, hsfc_pkg::SGL_EXP_MAX, 23'd1};
                hsfc_pkg::CLS_FINITE: n3_res = {r2_sign, r2_exp, r2_frac};
                default:              n3_res = '0;
            endcase
        end else begin
            case (r2_cls)
                hsfc_pkg::CLS_ZERO:   n3_res = {16'b0, r2_sign, 15'b0};
                hsfc_pkg::CLS_INF:    n3_res = {16'b0, r2_sign, hsfc_pkg::HALF_EXP_MAX, 10'b0};
                hsfc_pkg::CLS_NAN:    n3_res = {16'b0, r2_sign, hsfc_pkg::HALF_EXP_MAX, 10'd1};
                hsfc_pkg::CLS_FINITE: n3_res = {16'b0, r2_sign, r2_exp[4:0], r2_frac[9:0]};
                default:              n3_res = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (s3_rdy) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_rdy) begin
            r3_op  <= r2_op;
            r3_res <= n3_res;
        end
    end

    assign o_out.valid       = r3_vld;
    assign o_out.result_bits = r3_res;

    // Checks on the pipeline and the datapath.
    `HSFC_ASSERT(a_out_hold, i_clk, i_rst_n, r3_vld && !o_out.ready |=> r3_vld, "output beat lost under stall")
    `HSFC_ASSERT(a_in_enters, i_clk, i_rst_n, i_in.valid && i_in.ready |=> r1_vld, "accepted beat missing in stage 1")
    `HSFC_ASSERT(a_half_upper, i_clk, i_rst_n, r3_vld && (r3_op == hsfc_pkg::OP_S2H) |-> r3_res[31:16] == 16'b0, "half result has upper bits set")
    `HSFC_ASSERT_NEVER(a_sub_shift, i_clk, i_rst_n, r1_vld && (r1_op == hsfc_pkg::OP_H2S) && r1_sub && ((r1_sh == 5'd0) || (r1_sh > 5'd10)), "half subnormal shift out of range")

endmodule
